// File: src/lsiu_pkg.sv
package lsiu_pkg;

  localparam int NUM_LISTS    = 8;
  localparam int LIST_DEPTH   = 64;
  localparam int HANDLE_WIDTH = 32;

  localparam int MODE_W      = 2;
  localparam int SEL_W       = 3;
  localparam int POS_W       = 6;
  localparam int IN_HANDLE_W = 32;
  localparam int STATUS_W    = 2;
  localparam int READ_W      = 32;
  localparam int LEN_W       = 7;

  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W     = $clog2(LIST_DEPTH);
  localparam int LIST_ID_W = ($clog2(NUM_LISTS) > SEL_W) ? $clog2(NUM_LISTS) : SEL_W;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_LENGTH = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NULL  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // one item walking the cell chain, carrying its result once served
  typedef struct packed {
    logic                    valid;
    logic                    done;
    mode_t                   mode;
    logic [SEL_W-1:0]        list_sel;
    logic [POS_W-1:0]        position;
    logic [HANDLE_WIDTH-1:0] handle;
    status_t                 status;
    logic [READ_W-1:0]       read_value;
    logic [LEN_W-1:0]        list_length;
  } tok_t;

endpackage

// File: src/lsiu_cell.sv
module lsiu_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [lsiu_pkg::LIST_ID_W-1:0]   cell_id,
  input  lsiu_pkg::tok_t                   tok_in,
  output lsiu_pkg::tok_t                   tok_out
);
  import lsiu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  tok_t                    op_r, op_nxt;
  tok_t                    tok_out_r, tok_out_nxt;
  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]        wr_idx_r, wr_idx_nxt;
  logic                    rd_pend_r, rd_pend_nxt;

  logic [HANDLE_WIDTH-1:0] mem [LIST_DEPTH];
  logic [HANDLE_WIDTH-1:0] rd_q_r;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [HANDLE_WIDTH-1:0] wr_data;

  logic                    match;
  logic                    pos_ok;
  tok_t                    res;

  assign match  = tok_in.valid && !tok_in.done &&
                  (LIST_ID_W'(tok_in.list_sel) == cell_id);
  assign pos_ok = CMP_W'(tok_in.position) < CMP_W'(cnt_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    tok_out_nxt = tok_in;
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    rd_pend_nxt = rd_pend_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = tok_in.handle;
    res             = (state_r == S_IDLE) ? tok_in : op_r;
    res.valid       = 1'b1;
    res.done        = 1'b1;
    res.status      = ST_OK;
    res.read_value  = '0;
    res.list_length = LEN_W'(cnt_r);

    unique case (state_r)
      S_IDLE: begin
        if (match) begin
          tok_out_nxt = res;
          unique case (tok_in.mode)
            MODE_APPEND: begin
              if (tok_in.handle == '0) begin
                tok_out_nxt.status = ST_NULL;
              end else if (cnt_r == CNT_W'(LIST_DEPTH)) begin
                tok_out_nxt.status = ST_FULL;
              end else begin
                wr_en                   = 1'b1;
                wr_addr                 = IDX_W'(cnt_r);
                cnt_nxt                 = CNT_W'(cnt_r + 1'b1);
                tok_out_nxt.list_length = LEN_W'(cnt_nxt);
              end
            end
            MODE_DELETE: begin
              if (!pos_ok) begin
                tok_out_nxt.status = ST_RANGE;
              end else begin
                tok_out_nxt.valid = 1'b0;
                op_nxt            = tok_in;
                rd_idx_nxt        = CNT_W'(CNT_W'(tok_in.position) + 1'b1);
                wr_idx_nxt        = IDX_W'(tok_in.position);
                rd_pend_nxt       = 1'b0;
                state_nxt         = S_SHIFT;
              end
            end
            MODE_READ: begin
              if (!pos_ok) begin
                tok_out_nxt.status = ST_RANGE;
              end else begin
                tok_out_nxt.valid = 1'b0;
                op_nxt            = tok_in;
                rd_en             = 1'b1;
                rd_addr           = IDX_W'(tok_in.position);
                state_nxt         = S_RD_WAIT;
              end
            end
            MODE_LENGTH: begin
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        tok_out_nxt            = res;
        tok_out_nxt.read_value = READ_W'(rd_q_r);
        state_nxt              = S_IDLE;
      end
      S_SHIFT: begin
        tok_out_nxt.valid = 1'b0;
        if (rd_pend_r) begin
          wr_en      = 1'b1;
          wr_addr    = wr_idx_r;
          wr_data    = rd_q_r;
          wr_idx_nxt = IDX_W'(wr_idx_r + 1'b1);
        end
        if (rd_idx_r < cnt_r) begin
          rd_en       = 1'b1;
          rd_addr     = IDX_W'(rd_idx_r);
          rd_idx_nxt  = CNT_W'(rd_idx_r + 1'b1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            cnt_nxt                 = CNT_W'(cnt_r - 1'b1);
            tok_out_nxt             = res;
            tok_out_nxt.list_length = LEN_W'(cnt_nxt);
            state_nxt               = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      tok_out_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      tok_out_r <= tok_out_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    op_r     <= op_nxt;
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
  end

  // list entry memory, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign tok_out = tok_out_r;

endmodule

// File: src/multi_list_indexed_store_unit.sv
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_stall  | in_mode, in_list_sel, in_position, in_handle
// out      | out_valid / out_stall| out_status, out_read_value, out_list_length
//
// an item walks a chain of NUM_LISTS cells, one cell per cycle; the cell owning the list serves it
// append, length and rejected items pass every cell register, then the hold register and the output register
// read: the owning cell also waits for its registered memory read
// delete: the owning cell shifts each later entry down by one, one entry moved per cycle
// one item at a time; the next is taken once the previous result reaches the output register
// reset empties all lists; out_stall holds the result, and the next item waits until the held result can move out
module multi_list_indexed_store_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lsiu_pkg::MODE_W-1:0]       in_mode,
  input  logic [lsiu_pkg::SEL_W-1:0]        in_list_sel,
  input  logic [lsiu_pkg::POS_W-1:0]        in_position,
  input  logic [lsiu_pkg::IN_HANDLE_W-1:0]  in_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lsiu_pkg::STATUS_W-1:0]     out_status,
  output logic [lsiu_pkg::READ_W-1:0]       out_read_value,
  output logic [lsiu_pkg::LEN_W-1:0]        out_list_length
);
  import lsiu_pkg::*;

  tok_t                tok [NUM_LISTS+1];
  tok_t                tail;

  logic                busy_r, busy_nxt;
  logic                hold_valid_r, hold_valid_nxt;
  status_t             hold_status_r;
  logic [READ_W-1:0]   hold_value_r;
  logic [LEN_W-1:0]    hold_len_r;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [READ_W-1:0]   out_value_r;
  logic [LEN_W-1:0]    out_len_r;
  logic                in_take;
  logic                move_out;

  assign in_take = in_valid && !busy_r;

  always_comb begin
    tok[0]             = '0;
    tok[0].valid       = in_take;
    tok[0].done        = 1'b0;
    tok[0].mode        = mode_t'(in_mode);
    tok[0].list_sel    = in_list_sel;
    tok[0].position    = in_position;
    tok[0].handle      = HANDLE_WIDTH'(in_handle);
    tok[0].status      = ST_OK;
    tok[0].read_value  = '0;
    tok[0].list_length = '0;
  end

  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_cell
    lsiu_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (LIST_ID_W'(g)),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  // an item no cell claimed addresses a list that does not exist
  always_comb begin
    tail = tok[NUM_LISTS];
    if (!tail.done) begin
      tail.status      = ST_RANGE;
      tail.read_value  = '0;
      tail.list_length = '0;
    end
  end

  assign move_out = hold_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    busy_nxt       = busy_r;
    hold_valid_nxt = hold_valid_r;
    out_valid_nxt  = out_valid_r;
    if (in_take) begin
      busy_nxt = 1'b1;
    end
    if (tail.valid) begin
      hold_valid_nxt = 1'b1;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (move_out) begin
      hold_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      busy_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (tail.valid) begin
      hold_status_r <= tail.status;
      hold_value_r  <= tail.read_value;
      hold_len_r    <= tail.list_length;
    end
    if (move_out) begin
      out_status_r <= hold_status_r;
      out_value_r  <= hold_value_r;
      out_len_r    <= hold_len_r;
    end
  end

  assign in_stall        = busy_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_list_length = out_len_r;

endmodule

// File: src/lsiu_checker.sv
module lsiu_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [lsiu_pkg::STATUS_W-1:0]     out_status,
  input  logic [lsiu_pkg::READ_W-1:0]       out_read_value,
  input  logic [lsiu_pkg::LEN_W-1:0]        out_list_length
);
  import lsiu_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_read_value) && $stable(out_list_length))
    else $error("stalled result changed");

  // one item in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  // failed operations return no data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_read_value == '0)
    else $error("data returned with a failing status");

  // a full list reports its full depth
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_list_length == LEN_W'(LIST_DEPTH))
    else $error("list full reported with a short count");

  // a null handle append leaves a valid count
  a_null_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NULL) |->
      {1'b0, out_list_length} <= (LEN_W + 1)'(LIST_DEPTH))
    else $error("count above list depth");

endmodule

bind multi_list_indexed_store_unit lsiu_checker u_lsiu_checker (.*);
